FILE: rtl/core/kfmt_pkg.sv
// Shared types, constants and key canonicalization for the key frequency mode table.
package kfmt_pkg;

   localparam int ENTRIES_DEF    = 128;
   localparam int COUNT_BITS_DEF = 16;
   localparam int KEY_BYTES_DEF  = 20;

   localparam int RAW_KEY_BYTES = 20;
   localparam int RAW_KEY_W     = RAW_KEY_BYTES * 8;
   localparam int TAG_W         = 32;
   localparam int HIT_W         = 7;
   localparam int TOP_W         = 16;

   localparam int REQ_TDATA_W = RAW_KEY_W + TAG_W;
   localparam int RSP_FIELD_W = HIT_W + TOP_W + 1 + 1 + TAG_W;
   localparam int RSP_TDATA_W = ((RSP_FIELD_W + 7) / 8) * 8;

   typedef enum logic [1:0] {
      ACT_COUNT  = 2'd0,
      ACT_REPORT = 2'd1,
      ACT_MATCH  = 2'd2,
      ACT_RSVD   = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_WRITE,
      ST_RESP
   } state_type;

   // A key ends at its first zero byte; bytes past it or past nbytes read as zero.
   function automatic logic [RAW_KEY_W-1:0] canon_key(input logic [RAW_KEY_W-1:0] raw,
                                                      input int nbytes);
      logic                 ended;
      logic [RAW_KEY_W-1:0] k;
      ended = 1'b0;
      k     = '0;
      for (int n = 0; n < RAW_KEY_BYTES; n++) begin
         if (n >= nbytes || raw[8*n +: 8] == 8'd0) begin
            ended = 1'b1;
         end
         if (!ended) begin
            k[8*n +: 8] = raw[8*n +: 8];
         end
      end
      return k;
   endfunction

endpackage

FILE: rtl/core/key_frequency_mode_table_core.sv
// Key frequency mode table: sequencer and datapath around the slot memory.
//
//  channel | dir | handshake             | payload
//  req     | in  | req_tvalid/req_tready | tuser: action; tdata: key parts, tag
//  rsp     | out | rsp_tvalid/rsp_tready | tdata: hit_slot, top_count, flags, tag_out
//
// Count scans up to fill slots, stopping where the key is found; report scans all fill slots,
// where fill is the number of slots in use (never more than ENTRIES); match reads only the top
// slot; action 3 and empty-key count skip the scan. The single read port reads one slot per cycle.
// Slots fill from 0 upward and are never freed, so a fill counter stands in for valid bits.
// Reset clears the sequencer, the fill counter and the top entry; no clearing pass.
// req_tready is high only in idle; a stalled result holds until rsp_tready.
module key_frequency_mode_table_core #(
   parameter int ENTRIES    = kfmt_pkg::ENTRIES_DEF,
   parameter int COUNT_BITS = kfmt_pkg::COUNT_BITS_DEF,
   parameter int KEY_BYTES  = kfmt_pkg::KEY_BYTES_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // [63:0] key_part0, [127:64] key_part1, [159:128] key_part2, [191:160] tag
   input  logic [kfmt_pkg::REQ_TDATA_W-1:0]  req_tdata,
   // [1:0] action
   input  logic [1:0]                        req_tuser,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // [6:0] hit_slot, [22:7] top_count, [23] is_match, [24] table_full, [56:25] tag_out
   output logic [kfmt_pkg::RSP_TDATA_W-1:0]  rsp_tdata
);
   import kfmt_pkg::*;

   localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int CNT_W = IDX_W + 1;
   localparam int KEY_W = KEY_BYTES * 8;
   localparam int MEM_W = KEY_W + COUNT_BITS;
   localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

   state_type              state_ff, state_in;
   action_type             act_ff, act_in;
   logic [KEY_W-1:0]       key_ff, key_in;
   logic [TAG_W-1:0]       tag_ff, tag_in;
   logic [CNT_W-1:0]       fill_ff, fill_in;
   logic [CNT_W-1:0]       rd_idx_ff, rd_idx_in;
   logic                   pend_ff, pend_in;
   logic [IDX_W-1:0]       pend_idx_ff, pend_idx_in;
   logic [COUNT_BITS-1:0]  best_ff, best_in;
   logic [IDX_W-1:0]       best_slot_ff, best_slot_in;
   logic [IDX_W-1:0]       top_slot_ff, top_slot_in;
   logic [COUNT_BITS-1:0]  top_value_ff, top_value_in;
   logic [IDX_W-1:0]       wr_addr_ff, wr_addr_in;
   logic [MEM_W-1:0]       wr_data_ff, wr_data_in;
   logic [IDX_W-1:0]       hit_ff, hit_in;
   logic                   match_ff, match_in;
   logic                   full_ff, full_in;

   logic                   req_fire, rsp_fire;
   logic [RAW_KEY_W-1:0]   canon;
   logic                   in_key_empty;
   action_type             req_act;
   logic [CNT_W-1:0]       scan_end;
   logic                   more;
   logic                   issue;
   logic                   done;
   logic                   eq;
   logic                   found;
   logic [IDX_W-1:0]       rd_addr;
   logic [MEM_W-1:0]       mem_q;
   logic [KEY_W-1:0]       mem_key;
   logic [COUNT_BITS-1:0]  mem_cnt;
   logic [COUNT_BITS-1:0]  cnt_inc;
   logic                   wr_en;
   logic [HIT_W+IDX_W-1:0] hit_ext;
   logic [TOP_W+COUNT_BITS-1:0] top_ext;

   assign req_fire     = req_tvalid && req_tready;
   assign rsp_fire     = rsp_tvalid && rsp_tready;
   assign req_act      = action_type'(req_tuser);
   assign canon        = canon_key(req_tdata[RAW_KEY_W-1:0], KEY_BYTES);
   assign in_key_empty = (canon[7:0] == 8'd0);

   assign mem_key  = mem_q[KEY_W-1:0];
   assign mem_cnt  = mem_q[MEM_W-1:KEY_W];
   assign cnt_inc  = (mem_cnt == COUNT_MAX) ? mem_cnt : mem_cnt + COUNT_BITS'(1);
   assign scan_end = (act_ff == ACT_MATCH) ? CNT_W'(1) : fill_ff;
   assign more     = (rd_idx_ff < scan_end);
   assign eq       = pend_ff && (mem_key == key_ff);
   assign found    = (state_ff == ST_SCAN) && (act_ff == ACT_COUNT) && eq;
   assign issue    = (state_ff == ST_SCAN) && !found && more;
   assign done     = (state_ff == ST_SCAN) && !pend_ff && !more;
   assign rd_addr  = (act_ff == ACT_MATCH) ? top_slot_ff : rd_idx_ff[IDX_W-1:0];
   assign wr_en    = (state_ff == ST_WRITE);

   kfmt_store #(
      .DEPTH  (ENTRIES),
      .WIDTH  (MEM_W),
      .ADDR_W (IDX_W)
   ) u_store (
      .clock   (clock),
      .rd_addr (rd_addr),
      .rd_data (mem_q),
      .wr_en   (wr_en),
      .wr_addr (wr_addr_ff),
      .wr_data (wr_data_ff)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (req_act == ACT_RSVD || (req_act == ACT_COUNT && in_key_empty)) begin
                  state_in = ST_RESP;
               end else begin
                  state_in = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            if (found) begin
               state_in = ST_WRITE;
            end else if (done) begin
               if (act_ff == ACT_COUNT && fill_ff < CNT_W'(ENTRIES)) begin
                  state_in = ST_WRITE;
               end else begin
                  state_in = ST_RESP;
               end
            end
         end
         ST_WRITE: state_in = ST_RESP;
         ST_RESP: begin
            if (rsp_fire) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      act_in       = act_ff;
      key_in       = key_ff;
      tag_in       = tag_ff;
      fill_in      = fill_ff;
      rd_idx_in    = rd_idx_ff;
      pend_in      = issue;
      pend_idx_in  = rd_addr;
      best_in      = best_ff;
      best_slot_in = best_slot_ff;
      top_slot_in  = top_slot_ff;
      top_value_in = top_value_ff;
      wr_addr_in   = wr_addr_ff;
      wr_data_in   = wr_data_ff;
      hit_in       = hit_ff;
      match_in     = match_ff;
      full_in      = full_ff;

      if (state_ff == ST_IDLE && req_fire) begin
         act_in       = req_act;
         key_in       = canon[KEY_W-1:0];
         tag_in       = req_tdata[RAW_KEY_W +: TAG_W];
         rd_idx_in    = '0;
         best_in      = '0;
         best_slot_in = '0;
         hit_in       = '0;
         match_in     = 1'b0;
         full_in      = 1'b0;
      end

      if (issue) begin
         rd_idx_in = rd_idx_ff + CNT_W'(1);
      end

      if (state_ff == ST_SCAN && pend_ff) begin
         unique case (act_ff)
            ACT_COUNT: begin
               if (eq) begin
                  hit_in     = pend_idx_ff;
                  wr_addr_in = pend_idx_ff;
                  wr_data_in = {cnt_inc, key_ff};
               end
            end
            ACT_REPORT: begin
               if (mem_cnt > best_ff) begin
                  best_in      = mem_cnt;
                  best_slot_in = pend_idx_ff;
               end
            end
            ACT_MATCH: begin
               match_in = eq && (key_ff[7:0] != 8'd0) && (top_value_ff != '0) &&
                          ({1'b0, top_slot_ff} < fill_ff);
            end
            ACT_RSVD: begin
               match_in = 1'b0;
            end
         endcase
      end

      if (done) begin
         unique case (act_ff)
            ACT_COUNT: begin
               if (fill_ff < CNT_W'(ENTRIES)) begin
                  hit_in     = fill_ff[IDX_W-1:0];
                  wr_addr_in = fill_ff[IDX_W-1:0];
                  wr_data_in = {COUNT_BITS'(1), key_ff};
                  fill_in    = fill_ff + CNT_W'(1);
               end else begin
                  full_in = 1'b1;
               end
            end
            ACT_REPORT: begin
               top_slot_in  = best_slot_ff;
               top_value_in = best_ff;
               hit_in       = best_slot_ff;
            end
            ACT_MATCH: hit_in = top_slot_ff;
            ACT_RSVD:  hit_in = '0;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         fill_ff      <= '0;
         pend_ff      <= 1'b0;
         top_slot_ff  <= '0;
         top_value_ff <= '0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         pend_ff      <= pend_in;
         top_slot_ff  <= top_slot_in;
         top_value_ff <= top_value_in;
      end
   end

   always_ff @(posedge clock) begin
      act_ff       <= act_in;
      key_ff       <= key_in;
      tag_ff       <= tag_in;
      rd_idx_ff    <= rd_idx_in;
      pend_idx_ff  <= pend_idx_in;
      best_ff      <= best_in;
      best_slot_ff <= best_slot_in;
      wr_addr_ff   <= wr_addr_in;
      wr_data_ff   <= wr_data_in;
      hit_ff       <= hit_in;
      match_ff     <= match_in;
      full_ff      <= full_in;
   end

   assign hit_ext = {{HIT_W{1'b0}}, hit_ff};
   assign top_ext = {{TOP_W{1'b0}}, top_value_ff};

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = (state_ff == ST_RESP);
   assign rsp_tdata  = {{(RSP_TDATA_W - RSP_FIELD_W){1'b0}}, tag_ff, full_ff, match_ff,
                        top_ext[TOP_W-1:0], hit_ext[HIT_W-1:0]};

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= CNT_W'(ENTRIES))
      else $error("fill count beyond table depth");

   a_fill_step: assert property (@(posedge clock) disable iff (reset)
      (fill_ff != $past(fill_ff)) |-> (fill_ff == $past(fill_ff) + CNT_W'(1)))
      else $error("fill count moved by more than one");

   a_full_hit: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && full_ff) |-> (hit_ff == '0 && act_ff == ACT_COUNT))
      else $error("dropped key reported with a slot");

   a_pend_scan: assert property (@(posedge clock) disable iff (reset)
      pend_ff |-> $past(state_ff) == ST_SCAN)
      else $error("memory read outstanding outside a scan");

   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_fire |=> req_tready)
      else $error("not idle after result transaction");

endmodule

FILE: rtl/core/kfmt_store.sv
// Slot memory: one write port, one registered read port.
module kfmt_store #(
   parameter int DEPTH  = kfmt_pkg::ENTRIES_DEF,
   parameter int WIDTH  = kfmt_pkg::RAW_KEY_W + kfmt_pkg::COUNT_BITS_DEF,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data
);
   import kfmt_pkg::*;

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
